// File: rtl/assert_macros.svh
// Assertion macros shared by the framer RTL.
// Every macro samples on the rising edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_RST(label, clk, rst_n, !(cond), msg)

`endif

// File: rtl/nsf_pkg.sv
// Package for the NMEA sentence framer: character constants, queue sizing
// and the descriptor that travels from the front to the back. No dependencies.
package nsf_pkg;

  // Framing characters.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [3:0] NIBBLE_MAX_DEC = 4'd9;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A_MINUS_TEN = 8'h37;

  // Default depth of the descriptor queue.
  localparam int QUEUE_DEPTH = 2;

  // Register index of start_delimiter (bit 2 of the byte address).
  localparam logic CFG_IDX_START = 1'b0;

  // Number of output byte slots one item can produce.
  localparam int SLOTS = 7;

  // One classified input item: which bytes it will produce and with what data.
  typedef struct packed {
    logic       delim;   // open a sentence first
    logic       bang;    // delimiter is '!' rather than '$'
    logic       has;     // a field character follows
    logic [7:0] ch;      // the field character
    logic       eof;     // close the field (comma or '*')
    logic       eos;     // close the sentence with the trailer
    logic [7:0] csum;    // final checksum, meaningful when eos is set
  } desc_t;

endpackage

// File: rtl/nsf_front.sv
// Front of the framer: accepts input words, tracks the open sentence and the
// running checksum, and turns each word into a descriptor. Uses nsf_pkg.
module nsf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_bang_i,
  input  logic           in_valid_i,
  input  logic           queue_full_i,
  input  logic           has_byte_i,
  input  logic [7:0]     field_byte_i,
  input  logic           end_of_field_i,
  input  logic           end_of_sentence_i,
  output logic           in_stall_o,
  output logic           push_o,
  output nsf_pkg::desc_t desc_o
);
  import nsf_pkg::*;

  logic       in_sentence_q, in_sentence_d;
  logic [7:0] xor_q, xor_d;
  logic       accept;
  logic       eof;
  logic [7:0] base_xor;
  logic [7:0] with_ch;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign eof        = end_of_field_i || end_of_sentence_i;

  // Classify the word and work out the checksum it leaves behind.
  always_comb begin
    base_xor = in_sentence_q ? xor_q : 8'h00;
    with_ch  = base_xor ^ (has_byte_i ? field_byte_i : 8'h00);

    desc_o.delim = !in_sentence_q;
    desc_o.bang  = start_bang_i;
    desc_o.has   = has_byte_i;
    desc_o.ch    = field_byte_i;
    desc_o.eof   = eof;
    desc_o.eos   = end_of_sentence_i;
    desc_o.csum  = with_ch;

    // A word with no character and no field end produces nothing.
    push_o = accept && (has_byte_i || eof);

    in_sentence_d = in_sentence_q;
    xor_d         = xor_q;
    if (push_o) begin
      if (end_of_sentence_i) begin
        in_sentence_d = 1'b0;
        xor_d         = 8'h00;
      end else begin
        in_sentence_d = 1'b1;
        xor_d         = with_ch ^ (eof ? CH_COMMA : 8'h00);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sentence_q <= 1'b0;
      xor_q         <= 8'h00;
    end else begin
      in_sentence_q <= in_sentence_d;
      xor_q         <= xor_d;
    end
  end

endmodule

// File: rtl/nsf_queue.sv
// Short descriptor queue between the front and the back of the framer.
// Uses nsf_pkg for the descriptor type and assert_macros.svh for checks.
module nsf_queue #(
  parameter int Depth = nsf_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nsf_pkg::desc_t wdata_i,
  input  logic           pop_i,
  output nsf_pkg::desc_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);
  import nsf_pkg::*;
  `include "assert_macros.svh"

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  desc_t            entries_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = entries_q[rptr_q];

  // Pointer and fill count bookkeeping.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wptr_q] <= wdata_i;
    end
  end

  `ASSERT_NEVER(q_no_overflow, clk_i, rst_ni, push_i && full_o, "queue written while full")
  `ASSERT_NEVER(q_no_underflow, clk_i, rst_ni, pop_i && empty_o, "queue read while empty")

endmodule

// File: rtl/nsf_back.sv
// Back of the framer (nsf_pkg, assert_macros.svh): takes queue descriptors and
// sends their bytes out one per cycle, unless stalled, via an output register.
module nsf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nsf_pkg::desc_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           run_last_o,
  output logic           sentence_done_o
);
  import nsf_pkg::*;
  `include "assert_macros.svh"

  // Slot positions within the bytes of one descriptor.
  localparam int SlotDelim = 0;
  localparam int SlotChar  = 1;
  localparam int SlotClose = 2;
  localparam int SlotHi    = 3;
  localparam int SlotLo    = 4;
  localparam int SlotCr    = 5;

  desc_t            work_q, work_d;
  logic [SLOTS-1:0] mask_q, mask_d;
  logic [SLOTS-1:0] sel;
  logic [SLOTS-1:0] rest;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             done_q, done_d;
  logic             out_adv;
  logic             emit;
  logic             free;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    hex_digit = (v <= NIBBLE_MAX_DEC) ? CH_ZERO + {4'h0, v} : CH_A_MINUS_TEN + {4'h0, v};
  endfunction

  function automatic logic [SLOTS-1:0] slot_mask(input desc_t d);
    slot_mask = {d.eos, d.eos, d.eos, d.eos, d.eof, d.has, d.delim};
  endfunction

  assign out_adv = !out_valid_q || !out_stall_i;

  // Pick the next pending slot, and reload from the queue as the last one goes.
  always_comb begin
    sel  = mask_q & (~mask_q + SLOTS'(1));
    rest = mask_q & ~sel;
    emit = out_adv && (mask_q != '0);
    free = (mask_q == '0) || (emit && (rest == '0));
    pop_o = free && !empty_i;

    work_d = work_q;
    mask_d = mask_q;
    if (pop_o) begin
      work_d = head_i;
      mask_d = slot_mask(head_i);
    end else if (emit) begin
      mask_d = rest;
    end

    if (sel[SlotDelim]) begin
      byte_d = work_q.bang ? CH_BANG : CH_DOLLAR;
    end else if (sel[SlotChar]) begin
      byte_d = work_q.ch;
    end else if (sel[SlotClose]) begin
      byte_d = work_q.eos ? CH_STAR : CH_COMMA;
    end else if (sel[SlotHi]) begin
      byte_d = hex_digit(work_q.csum[7:4]);
    end else if (sel[SlotLo]) begin
      byte_d = hex_digit(work_q.csum[3:0]);
    end else if (sel[SlotCr]) begin
      byte_d = CH_CR;
    end else begin
      byte_d = CH_LF;
    end
    last_d = (rest == '0);
    done_d = sel[SLOTS-1];

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_adv) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (emit) begin
      byte_q <= byte_d;
      last_q <= last_d;
      done_q <= done_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = byte_q;
  assign run_last_o      = last_q;
  assign sentence_done_o = done_q;

  `ASSERT_RST(done_is_last, clk_i, rst_ni, (out_valid_q && done_q) |-> last_q, "LF not last")
  `ASSERT_RST(load_when_free, clk_i, rst_ni, pop_o |=> (mask_q != '0), "empty descriptor loaded")

endmodule

// File: rtl/nmea_sentence_framer_unit.sv
// NMEA 0183 sentence framer.
//
// Input channel: one word per accepted cycle (in_valid_i high, in_stall_o
// low) carrying has_byte_i, field_byte_i, end_of_field_i, end_of_sentence_i.
// A word with no character and no field end is taken and dropped.
// Output channel: one sentence byte per accepted cycle (out_valid_o high,
// out_stall_i low); run_last_o marks the final byte of an input word and
// sentence_done_o the LF that ends a sentence.
// The first byte of a word reaches the output through the descriptor queue,
// the back end's work register and the output register. The back end sends
// one byte per cycle while out_stall_i is low; a word makes one byte for a
// plain character, up to seven for one that opens and closes a sentence. A
// two-entry descriptor queue lets the input keep one word per cycle while
// the output is busy or stalled; in_stall_o rises only when the queue is full.
// Configuration: start_delimiter at byte address 0 over the APB port
// (0 gives '$', 1 gives '!'); it applies to the next sentence opened.
// Reset closes any open sentence, clears the checksum, empties the queue and
// the output register, and selects '$'.
module nmea_sentence_framer_unit #(
  parameter int QueueDepth = nsf_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        has_byte_i,
  input  logic [7:0]  field_byte_i,
  input  logic        end_of_field_i,
  input  logic        end_of_sentence_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        sentence_done_o
);
  import nsf_pkg::*;

  logic  start_q, start_d;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;
  desc_t push_desc;
  desc_t head_desc;

  // Configuration register.
  assign pready = 1'b1;
  always_comb begin
    start_d = start_q;
    if (psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_START)) begin
      start_d = pwdata[0];
    end
    prdata = (paddr[2] == CFG_IDX_START) ? {31'h0, start_q} : 32'h0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= start_d;
    end
  end

  nsf_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_bang_i      (start_q),
    .in_valid_i        (in_valid_i),
    .queue_full_i      (full),
    .has_byte_i        (has_byte_i),
    .field_byte_i      (field_byte_i),
    .end_of_field_i    (end_of_field_i),
    .end_of_sentence_i (end_of_sentence_i),
    .in_stall_o        (in_stall_o),
    .push_o            (push),
    .desc_o            (push_desc)
  );

  nsf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_desc),
    .pop_i   (pop),
    .rdata_o (head_desc),
    .full_o  (full),
    .empty_o (empty)
  );

  nsf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_desc),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .run_last_o      (run_last_o),
    .sentence_done_o (sentence_done_o)
  );

endmodule

// File: bench/testbench.sv
// Self-checking testbench for nmea_sentence_framer_unit: drives field words and APB writes,
// predicts every framed sentence byte and compares it field by field on the output channel.
// Depends on nsf_pkg and on the framer RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nsf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned WORDS_PER_PHASE = 45;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam logic [2:0] START_ADDR = {CFG_IDX_START, 2'b00};

  // One field word as offered on the input channel.
  typedef struct packed {
    logic       has;
    logic [7:0] ch;
    logic       eof;
    logic       eos;
  } field_word_t;

  // One sentence byte as seen on the output channel.
  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       done;
  } sentence_byte_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  // A row of the directed table; typed rows carry their bytes, right-justified.
  typedef struct packed {
    row_kind_e   kind;
    logic        has;
    logic [7:0]  ch;
    logic        eof;
    logic        eos;
    logic        cfg_val;
    logic        typed;
    logic [2:0]  n;
    logic [55:0] bytes;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        has_byte_i = 1'b0;
  logic [7:0]  field_byte_i = '0;
  logic        end_of_field_i = 1'b0;
  logic        end_of_sentence_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        run_last_o;
  logic        sentence_done_o;

  nmea_sentence_framer_unit u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .has_byte_i, .field_byte_i, .end_of_field_i,
    .end_of_sentence_i, .out_valid_o, .out_stall_i, .out_byte_o, .run_last_o,
    .sentence_done_o
  );

  // Framer state as the testbench tracks it.
  logic           bang_sel = 1'b0;
  logic           sentence_open = 1'b0;
  logic [7:0]     checksum = '0;
  sentence_byte_t sentence_bytes_q[$];

  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned bytes_checked = 0;
  int unsigned sentences_seen = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_len = 0;
  int unsigned hold_left = 0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;

  dir_row_t dir_rows [0:24] = '{
    '{ROW_CFG,  1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 56'(0)},
    // Idle word: nothing comes out and no sentence opens.
    '{ROW_WORD, 1'b0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b1, 3'd0, 56'(0)},
    // Empty first field straight after reset.
    '{ROW_WORD, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 3'd2, 56'("$,")},
    '{ROW_WORD, 1'b1, "G",   1'b0, 1'b0, 1'b0, 1'b1, 3'd1, 56'("G")},
    '{ROW_WORD, 1'b1, "P",   1'b1, 1'b0, 1'b0, 1'b1, 3'd2, 56'("P,")},
    '{ROW_WORD, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 3'd1, 56'(",")},
    // Extremes and framing characters inside a field pass through as they are.
    '{ROW_WORD, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 3'd1, 56'(8'h00)},
    '{ROW_WORD, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b1, 3'd1, 56'(8'hFF)},
    '{ROW_WORD, 1'b1, ",",   1'b0, 1'b0, 1'b0, 1'b1, 3'd1, 56'(",")},
    '{ROW_WORD, 1'b1, "*",   1'b0, 1'b0, 1'b0, 1'b1, 3'd1, 56'("*")},
    '{ROW_WORD, 1'b1, "$",   1'b0, 1'b0, 1'b0, 1'b1, 3'd1, 56'("$")},
    '{ROW_WORD, 1'b1, "!",   1'b0, 1'b0, 1'b0, 1'b1, 3'd1, 56'("!")},
    '{ROW_WORD, 1'b1, CH_CR, 1'b1, 1'b0, 1'b0, 1'b1, 3'd2, 56'({CH_CR, ","})},
    // Sentence end without field end closes the last, empty field.
    '{ROW_WORD, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 3'd0, 56'(0)},
    '{ROW_WORD, 1'b1, "A",   1'b1, 1'b1, 1'b0, 1'b1, 3'd7,
      56'({"$A*41", CH_CR, CH_LF})},
    '{ROW_WORD, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 3'd6, 56'({"$*00", CH_CR, CH_LF})},
    '{ROW_CFG,  1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 3'd0, 56'(0)},
    '{ROW_WORD, 1'b1, "G",   1'b1, 1'b0, 1'b0, 1'b1, 3'd3, 56'("!G,")},
    // Delimiter change while a sentence is open only touches the next one.
    '{ROW_CFG,  1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 56'(0)},
    '{ROW_WORD, 1'b1, "X",   1'b0, 1'b1, 1'b0, 1'b0, 3'd0, 56'(0)},
    '{ROW_WORD, 1'b1, 8'hAB, 1'b0, 1'b1, 1'b0, 1'b1, 3'd7,
      56'({"$", 8'hAB, "*AB", CH_CR, CH_LF})},
    '{ROW_WORD, 1'b1, 8'h7F, 1'b1, 1'b1, 1'b0, 1'b1, 3'd7,
      56'({"$", 8'h7F, "*7F", CH_CR, CH_LF})},
    '{ROW_CFG,  1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 3'd0, 56'(0)},
    '{ROW_WORD, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 3'd6, 56'({"!*00", CH_CR, CH_LF})},
    '{ROW_CFG,  1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 56'(0)}
  };

  // Clock.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d bytes outstanding", cycles,
               sentence_bytes_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= hold_len;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch on %s: expected %0h, got %0h (cycle %0d)", what, want, got, cycles);
    end
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    return (nib <= NIBBLE_MAX_DEC) ? CH_ZERO + 8'(nib) : CH_A_MINUS_TEN + 8'(nib);
  endfunction

  // Works out the bytes a word frames and advances the sentence state; the bytes are
  // queued only when keep is set. Returns how many bytes the word makes.
  function automatic int frame_word(field_word_t w, bit keep);
    sentence_byte_t made [0:6];
    int n;
    logic closes;
    n = 0;
    closes = w.eof | w.eos;
    if (!w.has && !closes) return 0;
    if (!sentence_open) begin
      made[n++] = '{bang_sel ? CH_BANG : CH_DOLLAR, 1'b0, 1'b0};
      sentence_open = 1'b1;
      checksum = '0;
    end
    if (w.has) begin
      made[n++] = '{w.ch, 1'b0, 1'b0};
      checksum ^= w.ch;
    end
    if (w.eos) begin
      made[n++] = '{CH_STAR, 1'b0, 1'b0};
      made[n++] = '{hex_char(checksum[7:4]), 1'b0, 1'b0};
      made[n++] = '{hex_char(checksum[3:0]), 1'b0, 1'b0};
      made[n++] = '{CH_CR, 1'b0, 1'b0};
      made[n++] = '{CH_LF, 1'b0, 1'b1};
      sentence_open = 1'b0;
      checksum = '0;
    end else if (closes) begin
      made[n++] = '{CH_COMMA, 1'b0, 1'b0};
      checksum ^= CH_COMMA;
    end
    made[n-1].run_last = 1'b1;
    if (keep) begin
      for (int k = 0; k < n; k++) sentence_bytes_q.push_back(made[k]);
    end
    return n;
  endfunction

  // Output check: every byte taken is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_out
    sentence_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      bytes_checked++;
      if (sentence_done_o) sentences_seen++;
      if (sentence_bytes_q.size() == 0) begin
        note_mismatch("unexpected output byte", 0, out_byte_o);
      end else begin
        want = sentence_bytes_q.pop_front();
        if (out_byte_o !== want.ch) note_mismatch("out_byte", want.ch, out_byte_o);
        if (run_last_o !== want.run_last) note_mismatch("run_last", want.run_last, run_last_o);
        if (sentence_done_o !== want.done) note_mismatch("sentence_done", want.done,
                                                          sentence_done_o);
      end
    end
  end

  // Offers one word after a random idle gap and returns once it has been taken.
  task automatic drive_word(field_word_t w, bit typed, int n, logic [55:0] bytes);
    int made;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    has_byte_i <= w.has;
    field_byte_i <= w.ch;
    end_of_field_i <= w.eof;
    end_of_sentence_i <= w.eos;
    made = frame_word(w, !typed);
    if (typed) begin
      for (int k = 0; k < n; k++) begin
        sentence_bytes_q.push_back('{bytes[8*(n-1-k) +: 8], k == n - 1,
                                     w.eos && (k == n - 1)});
      end
    end
    if (made > 0) words_sent++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops offering words and waits until every expected byte has come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sentence_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= START_ADDR;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes start_delimiter and reads it back; the block must be idle.
  task automatic set_start_delim(logic val);
    logic [31:0] rd;
    apb_access(1'b1, {31'b0, val}, rd);
    bang_sel = val;
    apb_access(1'b0, '0, rd);
    if (rd[0] !== val) note_mismatch("start_delimiter readback", val, rd[0]);
  endtask

  // Mostly well-formed field text, with idle words and fully random words as noise.
  function automatic field_word_t rand_word();
    field_word_t w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w.ch = 8'($urandom_range(0, 255));
    if (pick < 8) begin
      w.has = 1'b0;
      w.eof = 1'b0;
      w.eos = 1'b0;
    end else if (pick < 20) begin
      w.has = 1'($urandom);
      w.eof = 1'($urandom);
      w.eos = 1'($urandom_range(0, 3) == 0);
    end else begin
      w.has = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 9) != 0) w.ch = 8'($urandom_range(8'h20, 8'h7E));
      w.eof = ($urandom_range(0, 4) == 0);
      w.eos = ($urandom_range(0, 11) == 0);
    end
    return w;
  endfunction

  // Stimulus.
  initial begin
    int unsigned phase_idle [0:3] = '{0, 56, 0, 15};
    int unsigned phase_stall [0:3] = '{0, 0, 56, 15};
    int unsigned phase_words;
    field_word_t w;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        set_start_delim(dir_rows[i].cfg_val);
      end else begin
        w = '{dir_rows[i].has, dir_rows[i].ch, dir_rows[i].eof, dir_rows[i].eos};
        drive_word(w, dir_rows[i].typed, dir_rows[i].n, dir_rows[i].bytes);
      end
    end

    // Random phases, each with its own idle and stall pattern; the delimiter alternates.
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      set_start_delim(p % 2 == 0);
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      phase_words = 0;
      while (phase_words < WORDS_PER_PHASE) begin
        if (p == 0 && phase_words == 20) begin
          // Long receiver hold-off while words keep coming, so the queue fills.
          hold_len = 80;
          hold_toggle = ~hold_toggle;
        end
        if (p == 1 && phase_words == 20) wait_idle();
        w = rand_word();
        if (w.has || w.eof || w.eos) phase_words++;
        drive_word(w, 1'b0, 0, '0);
      end
    end

    wait_idle();
    stall_pct = 0;
    if (sentence_bytes_q.size() != 0) begin
      note_mismatch("bytes never delivered", 0, sentence_bytes_q.size());
    end
    $display("Sent %0d field words over four idling patterns and both delimiters;",
             words_sent);
    $display("checked %0d sentence bytes including %0d complete sentences.",
             bytes_checked, sentences_seen);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: nmea_sentence_framer_unit.f
+incdir+rtl
rtl/nsf_pkg.sv
rtl/nsf_front.sv
rtl/nsf_queue.sv
rtl/nsf_back.sv
rtl/nmea_sentence_framer_unit.sv
bench/testbench.sv
